// File: hdl/idq_pkg.sv
// Package for the indexed deque: request and response structs, command
// and status codes shared by the control and top-level files.
// No dependencies.
`default_nettype none

package idq_pkg;

    localparam int CMD_W  = 3;
    localparam int DIN_W  = 32;
    localparam int POS_W  = 8;
    localparam int DOUT_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ       = 3'd4,
        CMD_WRITE      = 3'd5
    } idq_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } idq_status_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [DIN_W-1:0] data_in;
        logic [POS_W-1:0] position;
    } idq_req_t;

    typedef struct packed {
        logic [DOUT_W-1:0] data_out;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } idq_rsp_t;

    // memory strobes from the control unit
    typedef struct packed {
        logic we;
        logic re;
    } idq_mem_ctl_t;

    // what the response stage needs to know about an accepted request
    typedef struct packed {
        logic             is_read;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occupancy;
    } idq_info_t;

endpackage

`default_nettype wire

// File: hdl/indexed_deque.sv
// Top level of the indexed deque: request/response handshakes, the
// memory-read stage and the response register. Uses idq_pkg, idq_ctrl
// and idq_ram.
//
//   port group   dir  flow control       contents
//   s_*          in   s_valid/s_ready    idq_req_t: command, data_in, position
//   m_*          out  m_valid/m_ready    idq_rsp_t: data_out, status, occupancy
//
// One request is taken per cycle while the response side keeps up; a
// response passes through the memory read stage and then the response
// register after its request is accepted. Pointer and count change at
// acceptance, so a following request always sees the updated ring.
// Reset (aresetn low, synchronous) empties the deque; the memory is not
// cleared. When m_ready is low the read stage and response register hold
// and s_ready drops once both are full.
`default_nettype none

module indexed_deque
    import idq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire idq_req_t s_req,
    output logic          m_valid,
    input  wire logic     m_ready,
    output idq_rsp_t      m_rsp
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CPW = (DATA_WIDTH < DOUT_W) ? DATA_WIDTH : DOUT_W;

    idq_mem_ctl_t          mem_ctl;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
    idq_info_t             info;

    logic       s_fire, s1_advance;
    logic       s1_valid_reg;
    idq_info_t  s1_info_reg;
    logic       m_valid_reg;
    idq_rsp_t   m_rsp_reg, rsp_next;

    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_fire     = s_valid && s_ready;

    idq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s_fire),
        .req       (s_req),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .info      (info)
    );

    idq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_ctl.we),
        .re    (mem_ctl.re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // read data holds until the next accepted request, which cannot
    // arrive before this stage has moved on
    always_comb begin
        rsp_next           = '0;
        rsp_next.status    = s1_info_reg.status;
        rsp_next.occupancy = s1_info_reg.occupancy;
        if (s1_info_reg.is_read) begin
            rsp_next.data_out[CPW-1:0] = mem_rdata[CPW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_info_reg <= info;
        end
        if (s1_advance && s1_valid_reg) begin
            m_rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

`default_nettype wire

// File: hdl/idq_ram.sv
// Ring storage for the indexed deque: one synchronous single-port memory,
// read data registered. Depends on nothing but its parameters.
`default_nettype none

module idq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/idq_ctrl.sv
// Pointer and count control for the indexed deque: decodes a request,
// checks full/empty/range, forms the ring address and updates state.
// Uses idq_pkg.
`default_nettype none

module idq_ctrl
    import idq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       fire,
    input  wire idq_req_t                   req,
    output idq_mem_ctl_t                    mem_ctl,
    output logic      [$clog2(DEPTH)-1:0]   mem_addr,
    output logic      [DATA_WIDTH-1:0]      mem_wdata,
    output idq_info_t                       info
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int LW   = (CNTW > POS_W) ? CNTW : POS_W;
    localparam int CPW  = (DATA_WIDTH < DIN_W) ? DATA_WIDTH : DIN_W;

    logic [AW-1:0]   front_reg, front_next;
    logic [CNTW-1:0] count_reg, count_next;

    logic [AW-1:0]   front_dec, front_inc;
    logic [AW-1:0]   logical;
    logic [AW:0]     slot_sum;
    logic [AW-1:0]   slot;
    logic [LW-1:0]   pos_ext, cnt_ext;
    logic            full, empty, range_err;
    logic            we, re, is_read;
    logic [STAT_W-1:0] status;

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    assign full      = (count_reg == CNTW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pos_ext   = LW'(req.position);
    assign cnt_ext   = LW'(count_reg);
    assign range_err = (pos_ext >= cnt_ext);

    // logical index from the front for the back and indexed accesses
    always_comb begin
        case (req.command)
            CMD_PUSH_BACK: logical = AW'(count_reg);
            CMD_POP_BACK:  logical = AW'(count_reg - CNTW'(1));
            default:       logical = AW'(req.position);
        endcase
    end

    // both terms below DEPTH, so one conditional subtract wraps the ring
    assign slot_sum = {1'b0, front_reg} + {1'b0, logical};
    assign slot     = (slot_sum >= (AW + 1)'(DEPTH)) ? AW'(slot_sum - (AW + 1)'(DEPTH))
                                                     : slot_sum[AW-1:0];

    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        status     = ST_OK;
        is_read    = 1'b0;
        we         = 1'b0;
        re         = 1'b0;
        mem_addr   = slot;
        case (req.command)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    front_next = front_dec;
                    count_next = count_reg + CNTW'(1);
                    mem_addr   = front_dec;
                    we         = 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    count_next = count_reg + CNTW'(1);
                    we         = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    front_next = front_inc;
                    count_next = count_reg - CNTW'(1);
                    mem_addr   = front_reg;
                    re         = 1'b1;
                    is_read    = 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    count_next = count_reg - CNTW'(1);
                    re         = 1'b1;
                    is_read    = 1'b1;
                end
            end
            CMD_READ: begin
                if (range_err) begin
                    status = ST_RANGE;
                end else begin
                    re      = 1'b1;
                    is_read = 1'b1;
                end
            end
            CMD_WRITE: begin
                if (range_err) begin
                    status = ST_RANGE;
                end else begin
                    we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        mem_wdata            = '0;
        mem_wdata[CPW-1:0]   = req.data_in[CPW-1:0];
    end

    assign mem_ctl.we     = we & fire;
    assign mem_ctl.re     = re & fire;
    assign info.is_read   = is_read;
    assign info.status    = status;
    assign info.occupancy = OCC_W'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (fire) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
